// ----- hdl/h2r_pkg.sv -----
// Shared widths, types, codes and the channel scaling function for hsl_to_rgb.
`timescale 1ns / 1ps
`default_nettype none
package h2r_pkg;

	localparam int HUE_W   = 16;
	localparam int FRAC_W  = 16;
	localparam int REG_W   = 17;
	localparam int CH_W    = 8;
	localparam int SEC_W   = 3;
	localparam int PROD_W  = 2 * REG_W;
	localparam int LS_W    = PROD_W - FRAC_W;
	localparam int LVL_W   = 24;
	localparam int MAG_W   = 21;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [REG_W-1:0] SAT_RESET = REG_W'(65536);
	localparam logic [REG_W-1:0] LIT_RESET = REG_W'(32768);
	localparam logic [REG_W-1:0] HALF_Q16  = REG_W'(32768);

	// register index, taken from paddr[2]
	localparam logic REG_SAT = 1'b0;
	localparam logic REG_LIT = 1'b1;

	// hue sectors: red-yellow, yellow-green, green-cyan, cyan-blue, blue-magenta
	localparam logic [SEC_W-1:0] SEC_RY = 3'd0;
	localparam logic [SEC_W-1:0] SEC_YG = 3'd1;
	localparam logic [SEC_W-1:0] SEC_GC = 3'd2;
	localparam logic [SEC_W-1:0] SEC_CB = 3'd3;
	localparam logic [SEC_W-1:0] SEC_BM = 3'd4;

	typedef struct packed {
		logic                    black;
		logic                    neg;
		logic [MAG_W-1:0]        mag;
		logic signed [LVL_W-1:0] vmax;
		logic signed [LVL_W-1:0] vmin;
		logic [SEC_W-1:0]        sector;
		logic [FRAC_W-1:0]       frac;
	} h2r_span_t;

	function automatic logic [CH_W-1:0] to_channel(input logic signed [LVL_W-1:0] level);
		logic [FRAC_W+CH_W-1:0] scaled;
		scaled = level[FRAC_W-1:0] * (FRAC_W+CH_W)'(255);
		if (level <= 0)
			return '0;
		else if (level >= LVL_W'(65536))
			return '1;
		else
			return scaled[FRAC_W+CH_W-1:FRAC_W];
	endfunction

endpackage
`default_nettype wire

// ----- hdl/h2r_if.sv -----
// Stream interfaces: hue words in, RGB words out.
`timescale 1ns / 1ps
`default_nettype none
interface h2r_hue_if;
	logic        valid;
	logic        ready;
	logic [15:0] hue;

	modport source (output valid, output hue, input ready);
	modport sink (input valid, input hue, output ready);
endinterface

interface h2r_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

// ----- hdl/h2r_cfg.sv -----
// APB register file holding saturation and lightness.
`timescale 1ns / 1ps
`default_nettype none
module h2r_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [h2r_pkg::ADDR_W-1:0] paddr,
	input  wire logic [h2r_pkg::DATA_W-1:0] pwdata,
	output logic      [h2r_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output logic      [h2r_pkg::REG_W-1:0]  sat,
	output logic      [h2r_pkg::REG_W-1:0]  lit
);
	import h2r_pkg::*;

	logic [REG_W-1:0] sat_q;
	logic [REG_W-1:0] lit_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= SAT_RESET;
			lit_q <= LIT_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_SAT)
				sat_q <= pwdata[REG_W-1:0];
			else
				lit_q <= pwdata[REG_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_LIT)
			prdata = {{(DATA_W-REG_W){1'b0}}, lit_q};
		else
			prdata = {{(DATA_W-REG_W){1'b0}}, sat_q};
	end

	assign sat = sat_q;
	assign lit = lit_q;
endmodule
`default_nettype wire

// ----- hdl/h2r_bounds.sv -----
// Stages 1-2: lightness*saturation product, hue sector split, max/min levels.
`timescale 1ns / 1ps
`default_nettype none
module h2r_bounds (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	h2r_hue_if.sink                         hue_ch,
	input  wire logic [h2r_pkg::REG_W-1:0]  sat,
	input  wire logic [h2r_pkg::REG_W-1:0]  lit,
	output logic                            span_valid,
	input  wire logic                       span_ready,
	output h2r_pkg::h2r_span_t              span
);
	import h2r_pkg::*;

	logic                    v_s1;
	logic [PROD_W-1:0]       prod_s1;
	logic [SEC_W-1:0]        sector_s1;
	logic [FRAC_W-1:0]       frac_s1;
	logic [REG_W-1:0]        sat_s1;
	logic [REG_W-1:0]        lit_s1;
	logic                    v_s2;
	h2r_span_t               span_s2;
	logic                    rdy_s1;
	logic                    rdy_s2;
	logic [HUE_W+SEC_W-1:0]  h6;
	logic signed [LVL_W-1:0] l_x;
	logic signed [LVL_W-1:0] s_x;
	logic signed [LVL_W-1:0] ls_x;
	logic signed [LVL_W-1:0] vmax;
	logic signed [LVL_W-1:0] vmin;
	logic signed [LVL_W-1:0] diff;
	logic signed [LVL_W-1:0] diff_abs;

	assign rdy_s2       = !v_s2 | span_ready;
	assign rdy_s1       = !v_s1 | rdy_s2;
	assign hue_ch.ready = rdy_s1;
	assign h6           = hue_ch.hue * (HUE_W+SEC_W)'(6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rdy_s1)
			v_s1 <= hue_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && hue_ch.valid) begin
			prod_s1   <= lit * sat;
			sector_s1 <= h6[HUE_W+SEC_W-1:HUE_W];
			frac_s1   <= h6[FRAC_W-1:0];
			sat_s1    <= sat;
			lit_s1    <= lit;
		end
	end

	always_comb begin
		l_x  = {{(LVL_W-REG_W){1'b0}}, lit_s1};
		s_x  = {{(LVL_W-REG_W){1'b0}}, sat_s1};
		ls_x = {{(LVL_W-LS_W){1'b0}}, prod_s1[PROD_W-1:FRAC_W]};
		if (lit_s1 <= HALF_Q16)
			vmax = l_x + ls_x;
		else
			vmax = l_x + s_x - ls_x;
		vmin     = (l_x <<< 1) - vmax;
		diff     = vmax - vmin;
		diff_abs = diff[LVL_W-1] ? -diff : diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (rdy_s2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			span_s2.black  <= (vmax <= 0);
			span_s2.neg    <= diff[LVL_W-1];
			span_s2.mag    <= diff_abs[MAG_W-1:0];
			span_s2.vmax   <= vmax;
			span_s2.vmin   <= vmin;
			span_s2.sector <= sector_s1;
			span_s2.frac   <= frac_s1;
		end
	end

	assign span_valid = v_s2;
	assign span       = span_s2;
endmodule
`default_nettype wire

// ----- hdl/h2r_mix.sv -----
// Stages 3-4: ramp step, sector routing and scaling to 8-bit channels.
`timescale 1ns / 1ps
`default_nettype none
module h2r_mix (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               span_valid,
	output logic                    span_ready,
	input  wire h2r_pkg::h2r_span_t span,
	h2r_rgb_if.source               rgb_ch
);
	import h2r_pkg::*;

	logic                    v_s3;
	logic signed [LVL_W-1:0] t_s3;
	logic signed [LVL_W-1:0] vmax_s3;
	logic signed [LVL_W-1:0] vmin_s3;
	logic [SEC_W-1:0]        sector_s3;
	logic                    black_s3;
	logic                    v_s4;
	logic [CH_W-1:0]         red_s4;
	logic [CH_W-1:0]         green_s4;
	logic [CH_W-1:0]         blue_s4;
	logic                    rdy_s3;
	logic                    rdy_s4;
	logic [MAG_W+FRAC_W-1:0] step;
	logic signed [LVL_W-1:0] t_mag;
	logic signed [LVL_W-1:0] rise;
	logic signed [LVL_W-1:0] fall;
	logic signed [LVL_W-1:0] lr;
	logic signed [LVL_W-1:0] lg;
	logic signed [LVL_W-1:0] lb;

	assign rdy_s4     = !v_s4 | rgb_ch.ready;
	assign rdy_s3     = !v_s3 | rdy_s4;
	assign span_ready = rdy_s3;

	assign step  = span.mag * span.frac;
	assign t_mag = {{(LVL_W-MAG_W){1'b0}}, step[MAG_W+FRAC_W-1:FRAC_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (rdy_s3)
			v_s3 <= span_valid;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && span_valid) begin
			t_s3      <= span.neg ? -t_mag : t_mag;
			vmax_s3   <= span.vmax;
			vmin_s3   <= span.vmin;
			sector_s3 <= span.sector;
			black_s3  <= span.black;
		end
	end

	always_comb begin
		rise = vmin_s3 + t_s3;
		fall = vmax_s3 - t_s3;
		case (sector_s3)
			SEC_RY: begin
				lr = vmax_s3; lg = rise;    lb = vmin_s3;
			end
			SEC_YG: begin
				lr = fall;    lg = vmax_s3; lb = vmin_s3;
			end
			SEC_GC: begin
				lr = vmin_s3; lg = vmax_s3; lb = rise;
			end
			SEC_CB: begin
				lr = vmin_s3; lg = fall;    lb = vmax_s3;
			end
			SEC_BM: begin
				lr = rise;    lg = vmin_s3; lb = vmax_s3;
			end
			default: begin
				lr = vmax_s3; lg = vmin_s3; lb = fall;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (rdy_s4)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			red_s4   <= black_s3 ? '0 : to_channel(lr);
			green_s4 <= black_s3 ? '0 : to_channel(lg);
			blue_s4  <= black_s3 ? '0 : to_channel(lb);
		end
	end

	assign rgb_ch.valid = v_s4;
	assign rgb_ch.red   = red_s4;
	assign rgb_ch.green = green_s4;
	assign rgb_ch.blue  = blue_s4;
endmodule
`default_nettype wire

// ----- hdl/hsl_to_rgb.sv -----
// Top level: HSL hue stream to RGB stream with APB-set saturation and lightness.
//
//  channel   dir   word
//  hue_ch    in    hue[15:0]            unsigned Q0.16 turn fraction
//  rgb_ch    out   red, green, blue     8 bits each
//  apb       in    saturation @0x0, lightness @0x4, Q1.16, 17 bits
//
// One word per cycle while rgb_ch is not stalled; a word accepted on hue_ch
// raises rgb_ch.valid once it has passed through every register stage.
// Four register stages: product, max/min, ramp step multiply, channel out.
// Reset clears stage valids; saturation = 1.0, lightness = 0.5.
// Each stage takes a word when empty or when its successor moves, so a
// stall on rgb_ch backs up stage by stage without loss or repeat.
`timescale 1ns / 1ps
`default_nettype none
module hsl_to_rgb (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	h2r_hue_if.sink                         hue_ch,
	h2r_rgb_if.source                       rgb_ch,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [h2r_pkg::ADDR_W-1:0] paddr,
	input  wire logic [h2r_pkg::DATA_W-1:0] pwdata,
	output logic      [h2r_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);
	import h2r_pkg::*;

	logic [REG_W-1:0] sat;
	logic [REG_W-1:0] lit;
	logic             span_valid;
	logic             span_ready;
	h2r_span_t        span;

	h2r_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sat     (sat),
		.lit     (lit)
	);

	h2r_bounds u_bounds (
		.clk        (clk),
		.arst_n     (arst_n),
		.hue_ch     (hue_ch),
		.sat        (sat),
		.lit        (lit),
		.span_valid (span_valid),
		.span_ready (span_ready),
		.span       (span)
	);

	h2r_mix u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.span_valid (span_valid),
		.span_ready (span_ready),
		.span       (span),
		.rgb_ch     (rgb_ch)
	);
endmodule
`default_nettype wire
